FILE: src/tmh_pkg.sv
// shared types and constants for the tagged max-heap
package tmh_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned TAG_W = 7;
  localparam int unsigned CNT_W = 8;
  localparam int unsigned ST_W  = 2;

  // func codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } entry_t;

  // datapath operations issued by the controller, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INS_START,
    OP_INS_READ,
    OP_INS_STEP,
    OP_PLACE,
    OP_RM_START,
    OP_RM_LOAD,
    OP_RM_READ,
    OP_RM_STEP,
    OP_RESULT
  } tmh_op_e;

  typedef struct packed {
    tmh_op_e         op;
    logic [ST_W-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic remove;
    logic at_root;
    logic ch_over;
    logic ins_gt;
    logic rm_stop;
    logic out_free;
  } sts_t;

endpackage

FILE: src/tmh_if.sv
// handshake channels for heap requests and results
interface tmh_in_if;
  import tmh_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, func, key, input ready);
  modport sink   (input valid, func, key, output ready);
endinterface

interface tmh_out_if;
  import tmh_pkg::*;
  logic             valid;
  logic             ready;
  logic [TAG_W-1:0] removed_tag;
  logic [ST_W-1:0]  status;
  logic [CNT_W-1:0] entry_count;

  modport source (output valid, removed_tag, status, entry_count, input ready);
  modport sink   (input valid, removed_tag, status, entry_count, output ready);
endinterface

FILE: src/tmh_ctrl.sv
// sequencing state machine for insert and remove-max
module tmh_ctrl
  import tmh_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_INS_RD   = 3'd2;
  localparam logic [2:0] S_INS_CMP  = 3'd3;
  localparam logic [2:0] S_RM_LOAD  = 3'd4;
  localparam logic [2:0] S_RM_RD    = 3'd5;
  localparam logic [2:0] S_RM_CMP   = 3'd6;
  localparam logic [2:0] S_FIN      = 3'd7;

  logic [2:0]      state_q, state_d;
  logic [ST_W-1:0] res_q, res_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    res_d         = res_q;
    cmd_o.op      = OP_NONE;
    cmd_o.status  = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_d = ST_OK;
        if (sts_i.remove) begin
          if (sts_i.empty) begin
            res_d   = ST_EMPTY;
            state_d = S_FIN;
          end else begin
            cmd_o.op = OP_RM_START;
            state_d  = S_RM_LOAD;
          end
        end else begin
          if (sts_i.full) begin
            res_d   = ST_FULL;
            state_d = S_FIN;
          end else begin
            cmd_o.op = OP_INS_START;
            state_d  = S_INS_RD;
          end
        end
      end
      S_INS_RD: begin
        if (sts_i.at_root) begin
          cmd_o.op = OP_PLACE;
          state_d  = S_FIN;
        end else begin
          cmd_o.op = OP_INS_READ;
          state_d  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts_i.ins_gt) begin
          cmd_o.op = OP_INS_STEP;
          state_d  = S_INS_RD;
        end else begin
          cmd_o.op = OP_PLACE;
          state_d  = S_FIN;
        end
      end
      S_RM_LOAD: begin
        cmd_o.op = OP_RM_LOAD;
        state_d  = S_RM_RD;
      end
      S_RM_RD: begin
        if (sts_i.ch_over) begin
          cmd_o.op = OP_PLACE;
          state_d  = S_FIN;
        end else begin
          cmd_o.op = OP_RM_READ;
          state_d  = S_RM_CMP;
        end
      end
      S_RM_CMP: begin
        if (sts_i.rm_stop) begin
          cmd_o.op = OP_PLACE;
          state_d  = S_FIN;
        end else begin
          cmd_o.op = OP_RM_STEP;
          state_d  = S_RM_RD;
        end
      end
      S_FIN: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.op = OP_RESULT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= ST_OK;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

endmodule

FILE: src/tmh_dp.sv
// heap storage, sift registers, compares and result register
module tmh_dp
  import tmh_pkg::*;
#(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  input  logic                    in_func_i,
  input  logic signed [KEY_W-1:0] in_key_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [TAG_W-1:0]        out_tag_o,
  output logic [ST_W-1:0]         out_status_o,
  output logic [CNT_W-1:0]        out_count_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned PW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = PW + 1;

  entry_t mem_q [CAPACITY];
  entry_t rd_a_q, rd_b_q;

  logic                    func_q;
  logic signed [KEY_W-1:0] key_q;
  logic [PW-1:0]           count_q, count_d;
  logic [PW-1:0]           pos_q, pos_d;
  logic [CW-1:0]           ch_q, ch_d;
  entry_t                  moved_q, moved_d;
  logic [TAG_W-1:0]        top_tag_q, top_tag_d;

  logic                    out_valid_q, out_valid_d;
  logic [TAG_W-1:0]        out_tag_q;
  logic [ST_W-1:0]         out_status_q;
  logic [CNT_W-1:0]        out_count_q;

  logic                    we;
  logic [AW-1:0]           waddr, raddr_a, raddr_b;
  entry_t                  wdata;

  logic                    take_b;
  logic [CW-1:0]           ch_sel;
  entry_t                  pick;
  logic [PW+TAG_W-1:0]     cnt_tag_ext;
  logic [PW+CNT_W-1:0]     cnt_out_ext;

  assign cnt_tag_ext = (PW + TAG_W)'(count_q);
  assign cnt_out_ext = (PW + CNT_W)'(count_q);

  // right child only when it exists and is strictly greater
  assign take_b = (ch_q < CW'(count_q)) && ($signed(rd_a_q.key) < $signed(rd_b_q.key));
  assign ch_sel = take_b ? ch_q + 1'b1 : ch_q;
  assign pick   = take_b ? rd_b_q : rd_a_q;

  assign sts_o.empty    = (count_q == '0);
  assign sts_o.full     = (count_q == PW'(CAPACITY));
  assign sts_o.remove   = (func_q == FUNC_REMOVE);
  assign sts_o.at_root  = (pos_q == PW'(1));
  assign sts_o.ch_over  = (ch_q > CW'(count_q));
  assign sts_o.ins_gt   = ($signed(moved_q.key) > $signed(rd_a_q.key));
  assign sts_o.rm_stop  = ($signed(moved_q.key) >= $signed(pick.key));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    we        = 1'b0;
    waddr     = AW'(pos_q - 1'b1);
    wdata     = moved_q;
    raddr_a   = '0;
    raddr_b   = '0;
    count_d   = count_q;
    pos_d     = pos_q;
    ch_d      = ch_q;
    moved_d   = moved_q;
    top_tag_d = top_tag_q;
    unique case (cmd_i.op)
      OP_INS_START: begin
        count_d     = count_q + 1'b1;
        pos_d       = count_q + 1'b1;
        moved_d.key = key_q;
        moved_d.tag = cnt_tag_ext[TAG_W-1:0];
      end
      OP_INS_READ: begin
        raddr_a = AW'((pos_q >> 1) - 1'b1);
      end
      OP_INS_STEP: begin
        we    = 1'b1;
        wdata = rd_a_q;
        pos_d = pos_q >> 1;
      end
      OP_PLACE: begin
        we = 1'b1;
      end
      OP_RM_START: begin
        raddr_a = '0;
        raddr_b = AW'(count_q - 1'b1);
      end
      OP_RM_LOAD: begin
        top_tag_d = rd_a_q.tag;
        moved_d   = rd_b_q;
        count_d   = count_q - 1'b1;
        pos_d     = PW'(1);
        ch_d      = CW'(2);
      end
      OP_RM_READ: begin
        raddr_a = AW'(ch_q - 1'b1);
        raddr_b = AW'(ch_q);
      end
      OP_RM_STEP: begin
        we    = 1'b1;
        wdata = pick;
        pos_d = PW'(ch_sel);
        ch_d  = ch_sel << 1;
      end
      OP_NONE, OP_LOAD, OP_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.op == OP_RESULT) begin
      out_valid_d = 1'b1;
    end
  end

  // node storage, one write and two registered reads a cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_a_q <= mem_q[raddr_a];
    rd_b_q <= mem_q[raddr_b];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      func_q <= in_func_i;
      key_q  <= in_key_i;
    end
    pos_q     <= pos_d;
    ch_q      <= ch_d;
    moved_q   <= moved_d;
    top_tag_q <= top_tag_d;
    if (cmd_i.op == OP_RESULT) begin
      out_status_q <= cmd_i.status;
      out_count_q  <= cnt_out_ext[CNT_W-1:0];
      out_tag_q    <= (cmd_i.status == ST_OK && func_q == FUNC_REMOVE) ? top_tag_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_tag_o    = out_tag_q;
  assign out_status_o = out_status_q;
  assign out_count_o  = out_count_q;

endmodule

FILE: src/tagged_max_heap.sv
// tagged max-heap priority queue, top level
// Binary max-heap of signed 32-bit keys, each tagged with the entry count
// held when it was inserted. func 0 inserts key, func 1 removes the maximum
// and returns its tag; removing from an empty heap (status 1) or inserting
// into a full one (status 2) leaves the heap unchanged. One item is worked
// at a time. Each level of a sift is a registered read of the node memory,
// then a compare and a write; a sift moves at most log2(CAPACITY) levels.
// A flagged item goes from dispatch straight to the result. Nothing needs
// clearing after reset. The result sits in an output register, so the next
// item is taken while it waits.
module tagged_max_heap
  import tmh_pkg::*;
#(
  parameter int unsigned CAPACITY = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tmh_in_if.sink    in_i,
  tmh_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  tmh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tmh_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_func_i    (in_i.func),
    .in_key_i     (in_i.key),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_tag_o    (out_o.removed_tag),
    .out_status_o (out_o.status),
    .out_count_o  (out_o.entry_count)
  );

  // a result never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_RESULT |-> sts.out_free)
    else $error("result loaded while output register busy");

  // output valid only rises after the controller issues a result
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.op == OP_RESULT))
    else $error("output valid without a result");

  // flagged items carry no tag
  a_err_tag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != ST_OK |-> out_o.removed_tag == '0)
    else $error("nonzero tag on flagged item");

endmodule
